[rtl/tcgr_pkg.sv]
package tcgr_pkg;

   // fixed field widths
   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned COLOR_W    = 32;
   localparam int unsigned FADDR_W    = 13;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned COL_W      = 13;
   localparam int unsigned STRIDE_W   = 13;
   localparam int unsigned GB_W       = 6;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;
   // character code times glyph size fits here
   localparam int unsigned PROD_W     = 14;

   // defaults of the top level parameters
   localparam int unsigned FONT_BYTES_DEF    = 8192;
   localparam int unsigned CELL_HEIGHT_DEF   = 16;
   localparam int unsigned MAX_ROW_PIXEL_DEF = 4095;

   // cell width is fixed by the 8-bit mask
   localparam int unsigned CELL_WIDTH = 8;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_NULL    = 8'd0;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;

   // item actions
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_PRINT = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BASE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_STRIDE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAW_COLOR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_BYTES  = 3'd4;

   // register reset values
   localparam logic [ADDR_W-1:0]   FRAME_BASE_RST   = 32'h0000_0000;
   localparam logic [COL_W-1:0]    SCREEN_WIDTH_RST = 13'd640;
   localparam logic [STRIDE_W-1:0] LINE_STRIDE_RST  = 13'd640;
   localparam logic [COLOR_W-1:0]  DRAW_COLOR_RST   = 32'hffff_ffff;
   localparam logic [GB_W-1:0]     GLYPH_BYTES_RST  = 6'd16;

   typedef struct packed {
      logic              action;
      logic [FADDR_W-1:0] font_address;
      logic [BYTE_W-1:0]  font_byte;
      logic [CHAR_W-1:0]  character;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  pixel_address;
      logic [BYTE_W-1:0]  pixel_mask;
      logic [COLOR_W-1:0] pixel_color;
      logic               last_row;
   } rsp_type;

   // one glyph row read issued by the sequencer
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] pixel_address;
      logic              last_row;
   } issue_type;

endpackage

[rtl/tcgr_font_store.sv]
module tcgr_font_store #(
   parameter int unsigned FONT_BYTES = tcgr_pkg::FONT_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(FONT_BYTES)-1:0]     wr_addr,
   input  logic [tcgr_pkg::BYTE_W-1:0]       wr_data,
   input  logic                              rd_en,
   input  logic [$clog2(FONT_BYTES)-1:0]     rd_addr,
   output logic [tcgr_pkg::BYTE_W-1:0]       rd_data
);

   logic [tcgr_pkg::BYTE_W-1:0] mem [FONT_BYTES];
   logic [tcgr_pkg::BYTE_W-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tcgr_out_stage.sv]
module tcgr_out_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  tcgr_pkg::issue_type          issue,
   input  logic [tcgr_pkg::BYTE_W-1:0]  rd_data,
   input  logic [tcgr_pkg::COLOR_W-1:0] color,
   output logic                         issue_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output tcgr_pkg::rsp_type            rsp_data
);

   logic                          s1_valid_ff;
   logic [tcgr_pkg::ADDR_W-1:0]   s1_addr_ff;
   logic                          s1_last_ff;
   logic                          rsp_valid_ff;
   tcgr_pkg::rsp_type             rsp_data_ff;
   logic                          out_free;

   // output register loads when empty or taken this cycle
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign issue_ready = !s1_valid_ff || out_free;

   // read stage: tracks the row whose glyph byte is in the read register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (issue.valid) begin
         s1_valid_ff <= 1'b1;
      end else if (out_free) begin
         s1_valid_ff <= 1'b0;
      end
      if (issue.valid) begin
         s1_addr_ff <= issue.pixel_address;
         s1_last_ff <= issue.last_row;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (out_free && s1_valid_ff) begin
         rsp_data_ff.pixel_address <= s1_addr_ff;
         rsp_data_ff.pixel_mask    <= rd_data;
         rsp_data_ff.pixel_color   <= color;
         rsp_data_ff.last_row      <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/text_console_glyph_renderer_core.sv]
// printable character: accepted, then set up (multiply, base address), then its start
// index reduced by k subtractions of FONT_BYTES (k = start index / FONT_BYTES, 0 or 1
// at defaults), then CELL_HEIGHT rows issued one per cycle from the font store port
// while the output is not stalled; font load: index reduction, then the store write;
// tab, newline, null: handled on accept; synchronous active-high reset clears cursor,
// registers and handshakes; the font store is not cleared and holds no data until loaded
module text_console_glyph_renderer_core #(
   parameter int unsigned FONT_BYTES    = tcgr_pkg::FONT_BYTES_DEF,
   parameter int unsigned CELL_HEIGHT   = tcgr_pkg::CELL_HEIGHT_DEF,
   parameter int unsigned MAX_ROW_PIXEL = tcgr_pkg::MAX_ROW_PIXEL_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tcgr_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tcgr_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tcgr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcgr_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int unsigned AW     = $clog2(FONT_BYTES);
   localparam int unsigned V_W    = (AW + 1 > tcgr_pkg::PROD_W) ? AW + 1 : tcgr_pkg::PROD_W;
   localparam int unsigned ROW_W  = $clog2(MAX_ROW_PIXEL + 1);
   localparam int unsigned SUM_W  = ROW_W + 6;
   localparam int unsigned RP_W   = ROW_W + tcgr_pkg::STRIDE_W;
   localparam int unsigned RC_W   = $clog2(CELL_HEIGHT);
   localparam logic [V_W-1:0]   FB_V      = V_W'(FONT_BYTES);
   localparam logic [AW:0]      FB_I      = (AW + 1)'(FONT_BYTES);
   localparam logic [RC_W-1:0]  LAST_ROW  = RC_W'(CELL_HEIGHT - 1);
   localparam logic [SUM_W-1:0] MAX_ROW_S = SUM_W'(MAX_ROW_PIXEL);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_BASE,
      ST_REDUCE,
      ST_ROWS
   } state_type;

   state_type                       state_ff, state_in;
   tcgr_pkg::req_type               item_ff, item_in;
   logic [V_W-1:0]                  v_ff, v_in;
   logic [AW-1:0]                   idx_ff, idx_in;
   logic [RC_W-1:0]                 row_cnt_ff, row_cnt_in;
   logic [RP_W-1:0]                 rowprod_ff, rowprod_in;
   logic [tcgr_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic [tcgr_pkg::COL_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]                crow_ff, crow_in;

   logic [tcgr_pkg::ADDR_W-1:0]     frame_base_ff;
   logic [tcgr_pkg::COL_W-1:0]      screen_width_ff;
   logic [tcgr_pkg::STRIDE_W-1:0]   line_stride_ff;
   logic [tcgr_pkg::COLOR_W-1:0]    draw_color_ff;
   logic [tcgr_pkg::GB_W-1:0]       glyph_bytes_ff;

   logic                            req_accept;
   logic                            issue_ready;
   tcgr_pkg::issue_type             issue;
   logic                            wr_en;
   logic                            rd_en;
   logic [AW-1:0]                   wr_addr;
   logic [tcgr_pkg::BYTE_W-1:0]     rd_data;

   logic                            cur_upd;
   logic                            cur_newline;
   logic [tcgr_pkg::COL_W-1:0]      col_step;
   logic [ROW_W-1:0]                row_step;
   logic [ROW_W-1:0]                row_adv;
   logic [ROW_W-1:0]                row_adv2;
   logic [SUM_W-1:0]                row_sum;
   logic [SUM_W-1:0]                row_sum2;
   logic                            wrap;
   logic [AW:0]                     idx_nxt;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff   <= tcgr_pkg::FRAME_BASE_RST;
         screen_width_ff <= tcgr_pkg::SCREEN_WIDTH_RST;
         line_stride_ff  <= tcgr_pkg::LINE_STRIDE_RST;
         draw_color_ff   <= tcgr_pkg::DRAW_COLOR_RST;
         glyph_bytes_ff  <= tcgr_pkg::GLYPH_BYTES_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            tcgr_pkg::CSR_FRAME_BASE:   frame_base_ff   <= csr_data;
            tcgr_pkg::CSR_SCREEN_WIDTH: screen_width_ff <= csr_data[tcgr_pkg::COL_W-1:0];
            tcgr_pkg::CSR_LINE_STRIDE:  line_stride_ff  <= csr_data[tcgr_pkg::STRIDE_W-1:0];
            tcgr_pkg::CSR_DRAW_COLOR:   draw_color_ff   <= csr_data;
            tcgr_pkg::CSR_GLYPH_BYTES:  glyph_bytes_ff  <= csr_data[tcgr_pkg::GB_W-1:0];
            default: ;
         endcase
      end
   end

   // cursor advance: column step, optional newline row step, then wrap check
   always_comb begin
      cur_newline = (state_ff == ST_IDLE) && (req_data.character == tcgr_pkg::CHAR_NEWLINE);
      row_sum = SUM_W'(crow_ff) + SUM_W'(CELL_HEIGHT);
      row_adv = (row_sum > MAX_ROW_S) ? ROW_W'(MAX_ROW_PIXEL) : row_sum[ROW_W-1:0];
      if (cur_newline) begin
         col_step = '0;
         row_step = row_adv;
      end else begin
         col_step = col_ff + tcgr_pkg::COL_W'(tcgr_pkg::CELL_WIDTH);
         row_step = crow_ff;
      end
      row_sum2 = SUM_W'(row_step) + SUM_W'(CELL_HEIGHT);
      row_adv2 = (row_sum2 > MAX_ROW_S) ? ROW_W'(MAX_ROW_PIXEL) : row_sum2[ROW_W-1:0];
      wrap = ({1'b0, col_step} + (tcgr_pkg::COL_W + 1)'(tcgr_pkg::CELL_WIDTH))
             > {1'b0, screen_width_ff};
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      v_in       = v_ff;
      idx_in     = idx_ff;
      row_cnt_in = row_cnt_ff;
      rowprod_in = rowprod_ff;
      addr_in    = addr_ff;
      col_in     = col_ff;
      crow_in    = crow_ff;
      cur_upd    = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = v_ff[AW-1:0];
      rd_en      = 1'b0;
      issue      = '0;
      idx_nxt    = (AW + 1)'(idx_ff) + (AW + 1)'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_in = req_data;
               if (req_data.action == tcgr_pkg::ACT_LOAD) begin
                  v_in     = V_W'(req_data.font_address);
                  state_in = ST_REDUCE;
               end else if (req_data.character == tcgr_pkg::CHAR_NULL) begin
                  state_in = ST_IDLE;
               end else if (req_data.character == tcgr_pkg::CHAR_NEWLINE ||
                            req_data.character == tcgr_pkg::CHAR_TAB) begin
                  cur_upd = 1'b1;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            v_in = V_W'(tcgr_pkg::PROD_W'(item_ff.character) *
                        tcgr_pkg::PROD_W'(glyph_bytes_ff));
            rowprod_in = RP_W'(crow_ff) * RP_W'(line_stride_ff);
            state_in   = ST_BASE;
         end
         ST_BASE: begin
            addr_in = frame_base_ff + tcgr_pkg::ADDR_W'({col_ff, 2'b00})
                      + tcgr_pkg::ADDR_W'({rowprod_ff, 2'b00});
            cur_upd  = 1'b1;
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            // shared subtractor brings the store index below the store size
            if (v_ff >= FB_V) begin
               v_in = v_ff - FB_V;
            end else if (item_ff.action == tcgr_pkg::ACT_LOAD) begin
               wr_en    = 1'b1;
               state_in = ST_IDLE;
            end else begin
               idx_in     = v_ff[AW-1:0];
               row_cnt_in = '0;
               state_in   = ST_ROWS;
            end
         end
         ST_ROWS: begin
            if (issue_ready) begin
               rd_en               = 1'b1;
               issue.valid         = 1'b1;
               issue.pixel_address = addr_ff;
               issue.last_row      = (row_cnt_ff == LAST_ROW);
               addr_in = addr_ff + tcgr_pkg::ADDR_W'({line_stride_ff, 2'b00});
               idx_in  = (idx_nxt == FB_I) ? '0 : idx_nxt[AW-1:0];
               if (row_cnt_ff == LAST_ROW) begin
                  state_in = ST_IDLE;
               end else begin
                  row_cnt_in = row_cnt_ff + RC_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cur_upd) begin
         col_in  = wrap ? '0 : col_step;
         crow_in = wrap ? row_adv2 : row_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         crow_ff  <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         crow_ff  <= crow_in;
      end
      item_ff    <= item_in;
      v_ff       <= v_in;
      idx_ff     <= idx_in;
      row_cnt_ff <= row_cnt_in;
      rowprod_ff <= rowprod_in;
      addr_ff    <= addr_in;
   end

   tcgr_font_store #(
      .FONT_BYTES (FONT_BYTES)
   ) u_font_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (item_ff.font_byte),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   tcgr_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .issue       (issue),
      .rd_data     (rd_data),
      .color       (draw_color_ff),
      .issue_ready (issue_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // cursor row never passes its saturation point
   a_row_sat: assert property (@(posedge clock) disable iff (reset)
      crow_ff <= ROW_W'(MAX_ROW_PIXEL))
      else $error("cursor row above maximum");

   // glyph index stays inside the store while rows are read
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROWS |-> (AW + 1)'(idx_ff) < FB_I)
      else $error("glyph index out of range");

   // the last row issue ends the character
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      issue.valid && issue.last_row |=> state_ff == ST_IDLE)
      else $error("rows continue after last row");

   // no row issue without room in the read stage
   a_issue_room: assert property (@(posedge clock) disable iff (reset)
      issue.valid |-> issue_ready && state_ff == ST_ROWS)
      else $error("row issued without room");

   // a font load never writes before its index is reduced
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> v_ff < FB_V && item_ff.action == tcgr_pkg::ACT_LOAD)
      else $error("font write with unreduced index");

endmodule
